// ===== src/mpem_pkg.sv =====
// shared types and constants for the multi-pattern expect matcher
package mpem_pkg;

    localparam int NUM_PATTERNS    = 4;
    localparam int MAX_PATTERN_LEN = 32;

    localparam int REQ_W    = 2;
    localparam int PIDX_W   = 2;
    localparam int CHAR_W   = 5;
    localparam int LEN_W    = 6;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int MIDX_W   = 3;
    localparam int CNT_W    = 3;
    localparam int TICK_W   = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 8;

    localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(MAX_PATTERN_LEN);
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_START = 2'd0,
        REQ_LOAD  = 2'd1,
        REQ_DATA  = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PENDING = 2'd0,
        ST_MATCHED = 2'd1,
        ST_TIMEOUT = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'b1;

    typedef struct packed {
        logic              start;
        logic              data_en;
        logic              load_en;
        logic [CHAR_W-1:0] char_index;
        logic [LEN_W-1:0]  load_len;
        logic [BYTE_W-1:0] byte_value;
    } cell_ctl_t;

    typedef struct packed {
        status_t           status;
        logic [MIDX_W-1:0] match_index;
    } result_t;

endpackage

// ===== src/multi_pattern_expect_matcher_top.sv =====
// top level of the multi-pattern expect matcher
//
//  channel | dir | handshake          | contents
//  s_*     | in  | s_tvalid/s_tready  | tuser req_type, tdata pattern/char index, length, byte
//  m_*     | out | m_tvalid/m_tready  | tuser status, tdata match_index
//  cfg_*   | in  | cfg_we             | pattern_count (0), timeout_ticks (1)
//
// one beat per cycle while s_tready is high: every pattern cell with index below pattern_count
// compares its expected byte in the same cycle, and a kill chain through the cells lets only the
// lowest-indexed completed pattern report. each result leaves through an output register.
// rst_n clears positions, lengths, tick count and session flag; pattern bytes are not cleared.
// a stalled m_tready is absorbed by a one-beat skid stage before s_tready drops.
module multi_pattern_expect_matcher_top
    import mpem_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // pattern_index, char_index, pattern_len, byte_value
    input  logic [REQ_W-1:0]       s_tuser,   // req_type
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // match_index
    output logic [STATUS_W-1:0]    m_tuser,   // status
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [CNT_W-1:0]  pattern_count_reg;
    logic [TICK_W-1:0] timeout_reg;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic              over_reg, over_next;

    logic              acc;
    req_t              req;
    logic [PIDX_W-1:0] pidx;
    logic [CHAR_W-1:0] cidx;
    logic [LEN_W-1:0]  plen;
    logic [BYTE_W-1:0] byte_value;
    logic [LEN_W-1:0]  sat_len;
    logic [TICK_W-1:0] tick_inc;

    logic              do_start, do_load, do_data;
    cell_ctl_t         ctl [NUM_PATTERNS];
    logic [NUM_PATTERNS:0]   kill;
    logic [NUM_PATTERNS-1:0] done;
    logic [MIDX_W-1:0] found;
    result_t           res;
    result_t           out_res;

    assign acc        = s_tvalid && s_tready;
    assign req        = req_t'(s_tuser);
    assign pidx       = s_tdata[1:0];
    assign cidx       = s_tdata[6:2];
    assign plen       = s_tdata[12:7];
    assign byte_value = s_tdata[20:13];
    assign sat_len    = (plen > MAX_LEN) ? MAX_LEN : plen;
    assign tick_inc   = (tick_reg == TICK_MAX) ? tick_reg : tick_reg + TICK_W'(1);

    assign do_start = acc && (req == REQ_START);
    assign do_load  = acc && (req == REQ_LOAD) && !over_reg;
    assign do_data  = acc && (req == REQ_DATA) && !over_reg;

    assign kill[0] = 1'b0;

    for (genvar g = 0; g < NUM_PATTERNS; g++)
    begin : g_cell
        always_comb
        begin
            ctl[g].start      = do_start;
            ctl[g].load_en    = do_load && (pidx == PIDX_W'(g));
            ctl[g].data_en    = do_data && (CNT_W'(g) < pattern_count_reg);
            ctl[g].char_index = cidx;
            ctl[g].load_len   = sat_len;
            ctl[g].byte_value = byte_value;
        end

        mpem_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl[g]),
            .kill_in  (kill[g]),
            .kill_out (kill[g+1]),
            .done     (done[g])
        );
    end

    // at most one cell reports thanks to the kill chain
    always_comb
    begin
        found = '0;
        for (int i = 0; i < NUM_PATTERNS; i++)
        begin
            if (done[i])
            begin
                found = found | MIDX_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        tick_next       = tick_reg;
        over_next       = over_reg;
        res.status      = ST_PENDING;
        res.match_index = '0;
        case (req)
            REQ_START:
            begin
                tick_next = '0;
                over_next = 1'b0;
            end
            REQ_LOAD:
            begin
                if (over_reg)
                begin
                    res.status = ST_IGNORED;
                end
            end
            REQ_DATA:
            begin
                if (over_reg)
                begin
                    res.status = ST_IGNORED;
                end
                else if (kill[NUM_PATTERNS])
                begin
                    res.status      = ST_MATCHED;
                    res.match_index = found;
                    over_next       = 1'b1;
                end
            end
            REQ_TICK:
            begin
                if (over_reg)
                begin
                    res.status = ST_IGNORED;
                end
                else
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= timeout_reg)
                    begin
                        res.status = ST_TIMEOUT;
                        over_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                res.status = ST_PENDING;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            over_reg <= 1'b0;
        end
        else if (acc)
        begin
            tick_reg <= tick_next;
            over_reg <= over_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_count_reg <= CNT_W'(1);
            timeout_reg       <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_COUNT: pattern_count_reg <= cfg_data[CNT_W-1:0];
                REG_TIMEOUT_TICKS: timeout_reg       <= cfg_data[TICK_W-1:0];
                default:           timeout_reg       <= timeout_reg;
            endcase
        end
    end

    mpem_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc),
        .in_data   (res),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_data  (out_res),
        .out_ready (m_tready)
    );

    assign m_tuser = out_res.status;
    assign m_tdata = OUT_TDATA_W'(out_res.match_index);

endmodule

// ===== src/mpem_cell.sv =====
// one pattern cell: stores a pattern, tracks its match position, passes the kill chain on
module mpem_cell
    import mpem_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_ctl_t ctl,
    input  logic      kill_in,
    output logic      kill_out,
    output logic      done
);

    logic [BYTE_W-1:0] pat_mem [MAX_PATTERN_LEN];
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic              pos_ok;
    logic              hit;
    logic [LEN_W-1:0]  pos_inc;

    // pos below len also keeps pos below the store depth
    assign pos_ok  = (len_reg != '0) && (pos_reg < len_reg);
    assign hit     = pos_ok && (pat_mem[pos_reg[CHAR_W-1:0]] == ctl.byte_value);
    assign pos_inc = pos_reg + LEN_W'(1);
    assign done    = ctl.data_en && !kill_in && hit && (pos_inc == len_reg);
    assign kill_out = kill_in | done;

    always_comb
    begin
        len_next = len_reg;
        pos_next = pos_reg;
        if (ctl.start)
        begin
            pos_next = '0;
        end
        else if (ctl.load_en)
        begin
            len_next = ctl.load_len;
        end
        else if (ctl.data_en && !kill_in)
        begin
            pos_next = hit ? pos_inc : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            pos_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_en)
        begin
            pat_mem[ctl.char_index] <= ctl.byte_value;
        end
    end

endmodule

// ===== src/mpem_out_skid.sv =====
// output register with a skid stage for result beats
module mpem_out_skid
    import mpem_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    in_take;

    assign in_ready  = !skid_valid_reg;
    assign in_take   = in_valid && !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_ready || !main_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_next       = in_data;
                main_valid_next = in_take;
            end
        end
        else if (in_take)
        begin
            // main beat is stalled, park the new one
            skid_next       = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the multi-pattern expect matcher
module tb;
    import mpem_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 450;
    localparam int REPORT_LIMIT   = 10;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [REQ_W-1:0]       s_tuser   = '0;
    logic                   m_tready  = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tready;
    logic                   m_tvalid;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]    m_tuser;

    multi_pattern_expect_matcher_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mirror of the matcher state
    logic [BYTE_W-1:0] exp_store [NUM_PATTERNS][MAX_PATTERN_LEN];
    logic [LEN_W-1:0]  exp_len   [NUM_PATTERNS];
    logic [LEN_W-1:0]  exp_pos   [NUM_PATTERNS];
    logic              exp_over;
    logic [TICK_W-1:0] exp_ticks;
    logic [CNT_W-1:0]  cfg_count;
    logic [TICK_W-1:0] cfg_timeout;

    result_t expected_replies [$];
    int      errors         = 0;
    int      live_items     = 0;
    int      stall_cycles   = 0;
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      hold_off_left  = 0;

    function automatic result_t predict_reply(req_t req, logic [PIDX_W-1:0] pidx,
                                              logic [CHAR_W-1:0] cidx, logic [LEN_W-1:0] len,
                                              logic [BYTE_W-1:0] b);
        result_t r;
        int      active;
        int      pos;
        r.status      = ST_PENDING;
        r.match_index = '0;
        if (req == REQ_START)
        begin
            for (int i = 0; i < NUM_PATTERNS; i++)
                exp_pos[i] = '0;
            exp_ticks = '0;
            exp_over  = 1'b0;
        end
        else if (exp_over)
            r.status = ST_IGNORED;
        else if (req == REQ_LOAD)
        begin
            if (pidx < NUM_PATTERNS)
            begin
                if (cidx < MAX_PATTERN_LEN)
                    exp_store[pidx][cidx] = b;
                exp_len[pidx] = (len > MAX_LEN) ? MAX_LEN : len;
            end
        end
        else if (req == REQ_DATA)
        begin
            active = (cfg_count > NUM_PATTERNS) ? NUM_PATTERNS : cfg_count;
            // first pattern to complete stops the scan
            for (int i = 0; i < active && r.match_index == 0; i++)
            begin
                pos = exp_pos[i];
                if (exp_len[i] == 0 || pos >= exp_len[i])
                    exp_pos[i] = '0;
                else if (exp_store[i][pos] == b)
                begin
                    exp_pos[i] = LEN_W'(pos + 1);
                    if (pos + 1 == exp_len[i])
                        r.match_index = MIDX_W'(i + 1);
                end
                else
                    exp_pos[i] = '0;
            end
            if (r.match_index != 0)
            begin
                r.status = ST_MATCHED;
                exp_over = 1'b1;
            end
        end
        else
        begin
            if (exp_ticks != TICK_MAX)
                exp_ticks++;
            if (exp_ticks >= cfg_timeout)
            begin
                r.status = ST_TIMEOUT;
                exp_over = 1'b1;
            end
        end
        return r;
    endfunction

    task automatic send_item(req_t req, logic [PIDX_W-1:0] pidx, logic [CHAR_W-1:0] cidx,
                             logic [LEN_W-1:0] len, logic [BYTE_W-1:0] b);
        result_t r;
        @(negedge clk);
        while (int'($urandom_range(99)) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {3'b000, b, len, cidx, pidx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = predict_reply(req, pidx, cidx, len, b);
        expected_replies.push_back(r);
        if (r.status != ST_IGNORED)
            live_items++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_replies.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PATTERN_COUNT)
            cfg_count = CNT_W'(value);
        else
            cfg_timeout = value;
    endtask

    // every store byte gets written once so no compare ever hits an unwritten byte
    task automatic test_fill_store();
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        for (int p = 0; p < NUM_PATTERNS; p++)
            for (int c = 0; c < MAX_PATTERN_LEN; c++)
                send_item(REQ_LOAD, PIDX_W'(p), CHAR_W'(c), LEN_W'(c + 1),
                          BYTE_W'($urandom_range(255)));
    endtask

    task automatic test_match_and_ignore();
        write_reg(REG_PATTERN_COUNT, 16'd4);
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_LOAD, 2'd0, 5'd0, 6'd2, 8'h00);
        send_item(REQ_LOAD, 2'd0, 5'd1, 6'd2, 8'hFF);
        send_item(REQ_LOAD, 2'd1, 5'd0, 6'd0, 8'h00);    // zero length, never matches
        send_item(REQ_LOAD, 2'd2, 5'd31, 6'd63, 8'hAA);  // length saturates
        send_item(REQ_LOAD, 2'd3, 5'd0, 6'd1, 8'h7E);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h00);    // miss is not rechecked at position zero
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'hFF);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'hFF);
        send_item(REQ_DATA, 2'd3, 5'd31, 6'd63, 8'h7E);  // session over from here on
        send_item(REQ_LOAD, 2'd0, 5'd0, 6'd1, 8'h55);
        send_item(REQ_TICK, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h7E);    // highest pattern index
    endtask

    task automatic test_shortened_pattern();
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_LOAD, 2'd0, 5'd0, 6'd1, 8'h00);    // position now at the length
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h00);
    endtask

    task automatic test_timeouts();
        write_reg(REG_TIMEOUT_TICKS, 16'd3);
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_TICK, 2'd3, 5'd31, 6'd63, 8'hFF);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h11);
        send_item(REQ_TICK, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_TICK, 2'd0, 5'd0, 6'd0, 8'h00);
        write_reg(REG_TIMEOUT_TICKS, 16'd0);
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_TICK, 2'd0, 5'd0, 6'd0, 8'h00);
        write_reg(REG_TIMEOUT_TICKS, 16'd1);
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_TICK, 2'd0, 5'd0, 6'd0, 8'h00);
    endtask

    task automatic test_pattern_count_limits();
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        write_reg(REG_PATTERN_COUNT, 16'd0);
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h00);
        write_reg(REG_PATTERN_COUNT, 16'd7);
        send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
        send_item(REQ_DATA, 2'd0, 5'd0, 6'd0, 8'h7E);
    endtask

    // sessions that mostly feed the next expected byte of some active pattern
    task automatic test_random_sessions(int send_pct, int stall_pct, int count, int timeout,
                                        int hold);
        int               target;
        int               active;
        int               p;
        int               len;
        int               pick;
        int               narrow;
        int               steps;
        logic [BYTE_W-1:0] b;
        write_reg(REG_PATTERN_COUNT, CFG_DATA_W'(count));
        write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(timeout));
        active         = (count > NUM_PATTERNS) ? NUM_PATTERNS : count;
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
        hold_off_left  = hold;
        target         = live_items + PHASE_ITEMS;
        while (live_items < target)
        begin
            send_item(REQ_START, PIDX_W'($urandom_range(3)), CHAR_W'($urandom_range(31)),
                      LEN_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
            if ($urandom_range(1) == 0)
            begin
                p    = $urandom_range(NUM_PATTERNS - 1);
                pick = $urandom_range(99);
                if (pick < 5)
                    len = 0;
                else if (pick < 85)
                    len = $urandom_range(6, 1);
                else
                    len = $urandom_range(MAX_PATTERN_LEN, 7);
                narrow = $urandom_range(1);
                for (int c = 0; c < ((len == 0) ? 1 : len); c++)
                begin
                    b = narrow ? BYTE_W'(8'h41 + $urandom_range(1)) : BYTE_W'($urandom_range(255));
                    send_item(REQ_LOAD, PIDX_W'(p), CHAR_W'(c), LEN_W'(len), b);
                end
            end
            steps = 0;
            while (!exp_over && steps < 60)
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    send_item(REQ_TICK, PIDX_W'($urandom_range(3)), CHAR_W'($urandom_range(31)),
                              LEN_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
                else if (pick < 11)
                    send_item(REQ_LOAD, PIDX_W'($urandom_range(3)), CHAR_W'($urandom_range(31)),
                              LEN_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
                else if (pick < 13)
                    send_item(REQ_START, 2'd0, 5'd0, 6'd0, 8'h00);
                else if (pick < 75 && active > 0)
                begin
                    p = $urandom_range(active - 1);
                    b = (exp_pos[p] < exp_len[p]) ? exp_store[p][exp_pos[p]] : exp_store[p][0];
                    send_item(REQ_DATA, PIDX_W'($urandom_range(3)), CHAR_W'($urandom_range(31)),
                              LEN_W'($urandom_range(63)), b);
                end
                else
                    send_item(REQ_DATA, PIDX_W'($urandom_range(3)), CHAR_W'($urandom_range(31)),
                              LEN_W'($urandom_range(63)), BYTE_W'($urandom_range(255)));
                steps++;
            end
            repeat ($urandom_range(2))
                send_item(req_t'($urandom_range(3, 1)), PIDX_W'($urandom_range(3)),
                          CHAR_W'($urandom_range(31)), LEN_W'($urandom_range(63)),
                          BYTE_W'($urandom_range(255)));
        end
    endtask

    always @(negedge clk)
    begin
        if (hold_off_left > 0)
        begin
            m_tready <= 1'b0;
            hold_off_left--;
        end
        else
            m_tready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_replies.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected beat: status %0d match %0d", m_tuser, m_tdata);
            end
            else
            begin
                want = expected_replies.pop_front();
                if (m_tuser !== want.status || m_tdata !== OUT_TDATA_W'(want.match_index))
                begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("mismatch: expected status %0d match %0d, got status %0d match %0d",
                                 want.status, want.match_index, m_tuser, m_tdata);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i < NUM_PATTERNS; i++)
        begin
            exp_len[i] = '0;
            exp_pos[i] = '0;
        end
        exp_over    = 1'b0;
        exp_ticks   = '0;
        cfg_count   = CNT_W'(1);
        cfg_timeout = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_fill_store();
        test_match_and_ignore();
        test_shortened_pattern();
        test_timeouts();
        test_pattern_count_limits();
        // receiver holds off for a while in the first phase so the input backs up
        test_random_sessions(0, 0, 4, 65535, 300);
        test_random_sessions(56, 0, 3, 20, 0);
        test_random_sessions(0, 56, 1, 1, 0);
        test_random_sessions(32, 32, 7, 9, 0);

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        errors += expected_replies.size();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/mpem_pkg.sv
src/mpem_cell.sv
src/mpem_out_skid.sv
src/multi_pattern_expect_matcher_top.sv
tb/sv/tb.sv
